[rtl/oriented_box_overlap_test_macros.svh]
// Assertion macros for the oriented box overlap test.
// Included by the checker module; depends on nothing else.
`ifndef ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_BOX_OVERLAP_TEST_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define OBB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("oriented box overlap assertion failed");

// Concurrent assertion that is also checked during reset.
`define OBB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("oriented box overlap assertion failed");

`endif

[rtl/obbsat_pkg.sv]
// Shared types and constants for the oriented box overlap test.
// No dependencies.
`default_nettype none

package obbsat_pkg;
  localparam int COORD_W = 32;
  localparam int ROT_BITS = 18;
  localparam int AXIS_W = 3 * ROT_BITS;
  localparam int PROD_W = COORD_W + ROT_BITS;
  localparam int DEFAULT_FRACTION_BITS = 16;

  typedef logic [COORD_W-1:0] ucoord_t;
  typedef logic signed [COORD_W-1:0] scoord_t;
  typedef logic signed [ROT_BITS-1:0] rot_t;
  typedef logic [ROT_BITS-1:0] rmag_t;
  typedef logic [PROD_W-1:0] uprod_t;
  typedef logic signed [PROD_W-1:0] sprod_t;

  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;
endpackage

`default_nettype wire

[rtl/obbsat_prod.sv]
// Product stage: all extent and offset products against the rotation entries.
// Depends on obbsat_pkg.
`default_nettype none

module obbsat_prod (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire obbsat_pkg::stage_ctl_t ctl,
  input  wire obbsat_pkg::ucoord_t  a  [3],
  input  wire obbsat_pkg::ucoord_t  b  [3],
  input  wire obbsat_pkg::scoord_t  t  [3],
  input  wire obbsat_pkg::rot_t     r  [3][3],
  input  wire obbsat_pkg::rmag_t    ra [3][3],
  output obbsat_pkg::uprod_t        pa [3][3][3],
  output obbsat_pkg::uprod_t        pb [3][3][3],
  output obbsat_pkg::sprod_t        pt [3][3][3],
  output logic                      valid
);
  import obbsat_pkg::*;

  // Index order is [coordinate][rotation row][rotation column].
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int q = 0; q < 3; q++) begin
            pa[i][j][q] <= PROD_W'(a[i]) * PROD_W'(ra[j][q]);
            pb[i][j][q] <= PROD_W'(b[i]) * PROD_W'(ra[j][q]);
            pt[i][j][q] <= sprod_t'(t[i]) * sprod_t'(r[j][q]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
  end
endmodule

`default_nettype wire

[rtl/oriented_box_overlap_test.sv]
// Oriented box overlap test: a four-stage pipeline that takes one box pair
// per cycle while the output is not stalled and returns its overlap flag.
// Stage one unpacks the rotation and takes magnitudes, stage two forms all
// products, stage three adds them per axis, and stage four compares the
// fifteen axes and holds the result. Results stalled at the output hold the
// whole pipeline. Depends on obbsat_pkg and obbsat_prod.
`default_nettype none

module oriented_box_overlap_test #(
  parameter int FRACTION_BITS = obbsat_pkg::DEFAULT_FRACTION_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_a_x,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_a_y,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_a_z,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_b_x,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_b_y,
  input  wire logic [obbsat_pkg::COORD_W-1:0]    extent_b_z,
  input  wire logic signed [obbsat_pkg::COORD_W-1:0] offset_x,
  input  wire logic signed [obbsat_pkg::COORD_W-1:0] offset_y,
  input  wire logic signed [obbsat_pkg::COORD_W-1:0] offset_z,
  input  wire logic [obbsat_pkg::AXIS_W-1:0]     axis_b0,
  input  wire logic [obbsat_pkg::AXIS_W-1:0]     axis_b1,
  input  wire logic [obbsat_pkg::AXIS_W-1:0]     axis_b2,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   overlap
);
  import obbsat_pkg::*;

  localparam int SHIFTED_W = COORD_W + FRACTION_BITS;
  localparam int RW = ((SHIFTED_W > PROD_W) ? SHIFTED_W : PROD_W) + 2;
  localparam int DW = PROD_W + 2;

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  ucoord_t in_a [3];
  ucoord_t in_b [3];
  scoord_t in_t [3];
  logic [AXIS_W-1:0] in_axis [3];

  assign in_a = '{extent_a_x, extent_a_y, extent_a_z};
  assign in_b = '{extent_b_x, extent_b_y, extent_b_z};
  assign in_t = '{offset_x, offset_y, offset_z};
  assign in_axis = '{axis_b0, axis_b1, axis_b2};

  // Stage one.
  logic    s1_valid;
  ucoord_t s1_a  [3];
  ucoord_t s1_b  [3];
  scoord_t s1_t  [3];
  ucoord_t s1_tm [3];
  rot_t    s1_r  [3][3];
  rmag_t   s1_ra [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_a[k] <= in_a[k];
        s1_b[k] <= in_b[k];
        s1_t[k] <= in_t[k];
        s1_tm[k] <= in_t[k][COORD_W-1] ? ucoord_t'(-in_t[k]) : ucoord_t'(in_t[k]);
      end
      for (int p = 0; p < 3; p++) begin
        for (int q = 0; q < 3; q++) begin
          s1_r[p][q] <= rot_t'(in_axis[q][p*ROT_BITS +: ROT_BITS]);
          s1_ra[p][q] <= in_axis[q][p*ROT_BITS + ROT_BITS - 1]
                         ? rmag_t'(-in_axis[q][p*ROT_BITS +: ROT_BITS])
                         : rmag_t'(in_axis[q][p*ROT_BITS +: ROT_BITS]);
        end
      end
    end
  end

  // Stage two.
  stage_ctl_t s1_ctl;
  logic       s2_valid;
  uprod_t     pa [3][3][3];
  uprod_t     pb [3][3][3];
  sprod_t     pt [3][3][3];
  ucoord_t    s2_a  [3];
  ucoord_t    s2_b  [3];
  ucoord_t    s2_tm [3];

  assign s1_ctl = '{en: en, valid: s1_valid};

  obbsat_prod u_prod (
    .clk   (clk),
    .rst   (rst),
    .ctl   (s1_ctl),
    .a     (s1_a),
    .b     (s1_b),
    .t     (s1_t),
    .r     (s1_r),
    .ra    (s1_ra),
    .pa    (pa),
    .pb    (pb),
    .pt    (pt),
    .valid (s2_valid)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a <= s1_a;
      s2_b <= s1_b;
      s2_tm <= s1_tm;
    end
  end

  // Stage three: the first three axes are those of A, the next three those
  // of B, then the nine cross products in row order.
  logic                 s3_valid;
  logic [RW-1:0]        s3_lhs_a [3];
  logic signed [DW-1:0] s3_d     [12];
  logic [RW-1:0]        s3_rhs   [15];
  logic [RW-1:0]        lhs_a_next [3];
  logic signed [DW-1:0] d_next     [12];
  logic [RW-1:0]        rhs_next   [15];

  for (genvar p = 0; p < 3; p++) begin : g_face
    assign lhs_a_next[p] = RW'(s2_tm[p]) << FRACTION_BITS;
    assign rhs_next[p] = (RW'(s2_a[p]) << FRACTION_BITS) + RW'(pb[0][p][0])
                         + RW'(pb[1][p][1]) + RW'(pb[2][p][2]);
    assign d_next[p] = DW'(pt[0][0][p]) + DW'(pt[1][1][p]) + DW'(pt[2][2][p]);
    assign rhs_next[3+p] = (RW'(s2_b[p]) << FRACTION_BITS) + RW'(pa[0][0][p])
                           + RW'(pa[1][1][p]) + RW'(pa[2][2][p]);
  end

  for (genvar p = 0; p < 3; p++) begin : g_cross_p
    for (genvar q = 0; q < 3; q++) begin : g_cross_q
      localparam int P1 = (p + 1) % 3;
      localparam int P2 = (p + 2) % 3;
      localparam int Q1 = (q + 1) % 3;
      localparam int Q2 = (q + 2) % 3;
      assign d_next[3 + 3*p + q] = DW'(pt[P2][P1][q]) - DW'(pt[P1][P2][q]);
      assign rhs_next[6 + 3*p + q] = RW'(pa[P1][P2][q]) + RW'(pa[P2][P1][q])
                                     + RW'(pb[Q1][p][Q2]) + RW'(pb[Q2][p][Q1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lhs_a <= lhs_a_next;
      s3_d <= d_next;
      s3_rhs <= rhs_next;
    end
  end

  // Stage four: an axis separates only when the distance strictly exceeds
  // the sum of the radii.
  logic [14:0] sep_axis;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sep_axis[i] = s3_lhs_a[i] > s3_rhs[i];
    end
    for (int i = 0; i < 12; i++) begin
      sep_axis[3+i] = RW'(s3_d[i][DW-1] ? -s3_d[i] : s3_d[i]) > s3_rhs[3+i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= !(|sep_axis);
    end
  end
endmodule

`default_nettype wire

[rtl/obbsat_checker.sv]
// Port-level checks for the oriented box overlap test, bound to the top level.
// Depends on oriented_box_overlap_test_macros.svh.
`default_nettype none
`include "oriented_box_overlap_test_macros.svh"

module obbsat_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic overlap
);
  logic accept;

  assign accept = in_valid && !in_stall;

  // The pipeline only holds when a finished result is held at the output.
  `OBB_ASSERT(a_stall_link, clk, rst, in_stall == (out_valid && out_stall))

  // A request that is accepted and then meets no stall on its way through the pipeline reaches the output.
  `OBB_ASSERT(a_latency, clk, rst, accept ##1 (!in_stall) [*3] |=> out_valid)

  `OBB_ASSERT(a_overlap_known, clk, rst, out_valid |-> !$isunknown(overlap))

  `OBB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
endmodule

bind oriented_box_overlap_test obbsat_checker u_obbsat_checker (.*);

`default_nettype wire

[tb/oriented_box_overlap_test_checker.sv]
// Checker for the oriented box overlap test: watches both channels, predicts
// the overlap flag of every accepted request and compares it with the result.
// Depends on obbsat_pkg.
`timescale 1ns / 1ps

module oriented_box_overlap_test_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  obbsat_pkg::ucoord_t               extent_a_x,
  input  obbsat_pkg::ucoord_t               extent_a_y,
  input  obbsat_pkg::ucoord_t               extent_a_z,
  input  obbsat_pkg::ucoord_t               extent_b_x,
  input  obbsat_pkg::ucoord_t               extent_b_y,
  input  obbsat_pkg::ucoord_t               extent_b_z,
  input  obbsat_pkg::scoord_t               offset_x,
  input  obbsat_pkg::scoord_t               offset_y,
  input  obbsat_pkg::scoord_t               offset_z,
  input  logic [obbsat_pkg::AXIS_W-1:0]     axis_b0,
  input  logic [obbsat_pkg::AXIS_W-1:0]     axis_b1,
  input  logic [obbsat_pkg::AXIS_W-1:0]     axis_b2,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              overlap,
  output int                                fail_count,
  output int                                pending
);
  import obbsat_pkg::*;

  localparam int FRAC = DEFAULT_FRACTION_BITS;

  bit expected_overlaps[$];

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit predict_overlap();
    longint ea[3];
    longint eb[3];
    longint t[3];
    longint r[3][3];
    longint ra[3][3];
    logic [AXIS_W-1:0] ax[3];
    rot_t entry;
    longint lhs;
    longint rhs;
    longint d;
    bit separated;
    int p1;
    int p2;
    int q1;
    int q2;
    separated = 0;
    ea[0] = longint'(extent_a_x);
    ea[1] = longint'(extent_a_y);
    ea[2] = longint'(extent_a_z);
    eb[0] = longint'(extent_b_x);
    eb[1] = longint'(extent_b_y);
    eb[2] = longint'(extent_b_z);
    t[0] = longint'(offset_x);
    t[1] = longint'(offset_y);
    t[2] = longint'(offset_z);
    ax[0] = axis_b0;
    ax[1] = axis_b1;
    ax[2] = axis_b2;
    for (int q = 0; q < 3; q++) begin
      for (int p = 0; p < 3; p++) begin
        entry = ax[q][ROT_BITS*p +: ROT_BITS];
        r[p][q] = longint'(entry);
        ra[p][q] = abs64(r[p][q]);
      end
    end
    for (int p = 0; p < 3; p++) begin
      lhs = abs64(t[p]) <<< FRAC;
      rhs = ea[p] <<< FRAC;
      for (int k = 0; k < 3; k++) rhs += eb[k] * ra[p][k];
      if (lhs > rhs) separated = 1;
    end
    for (int q = 0; q < 3; q++) begin
      d = 0;
      rhs = eb[q] <<< FRAC;
      for (int k = 0; k < 3; k++) begin
        d += t[k] * r[k][q];
        rhs += ea[k] * ra[k][q];
      end
      if (abs64(d) > rhs) separated = 1;
    end
    for (int p = 0; p < 3; p++) begin
      p1 = (p + 1) % 3;
      p2 = (p + 2) % 3;
      for (int q = 0; q < 3; q++) begin
        q1 = (q + 1) % 3;
        q2 = (q + 2) % 3;
        d = t[p2] * r[p1][q] - t[p1] * r[p2][q];
        rhs = ea[p1] * ra[p2][q] + ea[p2] * ra[p1][q]
            + eb[q1] * ra[p][q2] + eb[q2] * ra[p][q1];
        if (abs64(d) > rhs) separated = 1;
      end
    end
    return !separated;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_overlaps.push_back(predict_overlap());
      if (out_valid && !out_stall) begin
        if (expected_overlaps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else if (overlap !== expected_overlaps[0]) begin
          report_mismatch($sformatf("overlap is %b, expected %b",
                                    overlap, expected_overlaps[0]));
          void'(expected_overlaps.pop_front());
        end else begin
          void'(expected_overlaps.pop_front());
        end
      end
    end
    pending = expected_overlaps.size();
  end
endmodule

[tb/oriented_box_overlap_test_test.sv]
// Top of the oriented box overlap test bench: drives directed and random box
// pairs under several idle patterns and gives the verdict.
// Depends on obbsat_pkg, the block and oriented_box_overlap_test_checker.
`timescale 1ns / 1ps

module oriented_box_overlap_test_test;
  import obbsat_pkg::*;

  localparam int ONE = 1 << DEFAULT_FRACTION_BITS;
  localparam int ROT_MIN = -(1 << (ROT_BITS - 1));
  localparam int ROT_MAX = (1 << (ROT_BITS - 1)) - 1;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  ucoord_t extent_a_x = '0, extent_a_y = '0, extent_a_z = '0;
  ucoord_t extent_b_x = '0, extent_b_y = '0, extent_b_z = '0;
  scoord_t offset_x = '0, offset_y = '0, offset_z = '0;
  logic [AXIS_W-1:0] axis_b0 = '0, axis_b1 = '0, axis_b2 = '0;
  logic out_valid;
  logic out_stall = 0;
  logic overlap;
  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  oriented_box_overlap_test i_dut (.*);

  oriented_box_overlap_test_checker i_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) out_stall <= $urandom_range(99) < recv_stall_pct;

  function automatic logic [AXIS_W-1:0] pack_axis(input int x, input int y, input int z);
    rot_t ex;
    rot_t ey;
    rot_t ez;
    ex = rot_t'(x);
    ey = rot_t'(y);
    ez = rot_t'(z);
    return {ez, ey, ex};
  endfunction

  task automatic send_pair(input ucoord_t ax, ay, az, bx, by, bz,
                           input scoord_t tx, ty, tz,
                           input logic [AXIS_W-1:0] r0, r1, r2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    extent_a_x <= ax;
    extent_a_y <= ay;
    extent_a_z <= az;
    extent_b_x <= bx;
    extent_b_y <= by;
    extent_b_z <= bz;
    offset_x <= tx;
    offset_y <= ty;
    offset_z <= tz;
    axis_b0 <= r0;
    axis_b1 <= r1;
    axis_b2 <= r2;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int rand_rot(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_random_pair();
    int mode;
    int lim;
    ucoord_t e[6];
    scoord_t t[3];
    logic [AXIS_W-1:0] r[3];
    mode = $urandom_range(3);
    if (mode == 0) begin
      for (int k = 0; k < 6; k++) e[k] = $urandom;
      for (int k = 0; k < 3; k++) t[k] = $urandom;
      for (int k = 0; k < 3; k++) r[k] = AXIS_W'({$urandom, $urandom});
    end else begin
      lim = (mode == 1) ? (1 << 20) : (1 << 24);
      for (int k = 0; k < 6; k++) e[k] = $urandom_range(lim);
      for (int k = 0; k < 3; k++) t[k] = int'($urandom_range(6 * lim)) - 3 * lim;
      for (int k = 0; k < 3; k++)
        r[k] = (mode == 3)
          ? pack_axis(k == 0 ? ONE : rand_rot(64), k == 1 ? ONE : rand_rot(64),
                      k == 2 ? ONE : rand_rot(64))
          : pack_axis(rand_rot(ROT_MAX), rand_rot(ROT_MAX), rand_rot(ROT_MAX));
    end
    send_pair(e[0], e[1], e[2], e[3], e[4], e[5], t[0], t[1], t[2], r[0], r[1], r[2]);
  endtask

  initial begin
    logic [AXIS_W-1:0] ix;
    logic [AXIS_W-1:0] iy;
    logic [AXIS_W-1:0] iz;
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    ix = pack_axis(ONE, 0, 0);
    iy = pack_axis(0, ONE, 0);
    iz = pack_axis(0, 0, ONE);
    lo = pack_axis(ROT_MIN, ROT_MIN, ROT_MIN);
    hi = pack_axis(ROT_MAX, ROT_MAX, ROT_MAX);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, '0, '0, '0);
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 2 * ONE, 0, 0, ix, iy, iz);
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 2 * ONE + 1, 0, 0, ix, iy, iz);
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, -2 * ONE, 0, ix, iy, iz);
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, -2 * ONE - 1, ix, iy, iz);
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 0,
              pack_axis(46341, 46341, 0), pack_axis(-46341, 46341, 0), iz);
    send_pair('1, '1, '1, '1, '1, '1, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, lo, lo, lo);
    send_pair('1, '1, '1, '1, '1, '1, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh7fff_ffff, hi, hi, hi);
    send_pair(0, 0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1, lo, hi, '1);
    send_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, '0, '0, '0);
    send_pair('1, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0, ix, iy, iz);
    send_pair(0, 0, 0, '1, '1, '1, 32'sh8000_0000, 0, 0, hi, lo, hi);
    send_pair(ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, 0, 0, 0, pack_axis(0, 0, ONE),
              pack_axis(ONE, 0, 0), pack_axis(0, ONE, 0));
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, 3 * ONE, 3 * ONE, 0,
              pack_axis(2 * ONE, 0, 0), pack_axis(0, ONE, 0), pack_axis(0, 0, -ONE));
    send_pair(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, '1, '1, '1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (160) send_random_pair();
    end
    in_valid <= 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/obbsat_pkg.sv
rtl/obbsat_prod.sv
rtl/oriented_box_overlap_test.sv
rtl/obbsat_checker.sv
tb/oriented_box_overlap_test_checker.sv
tb/oriented_box_overlap_test_test.sv
